/* rtl/core/sorted_array_insert_remove_macros.svh */
// Assertion macros for the sorted array RTL.
`ifndef SORTED_ARRAY_INSERT_REMOVE_MACROS_SVH
`define SORTED_ARRAY_INSERT_REMOVE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SAI_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sorted array assertion failed");
// Next-cycle implication.
`define SAI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted array assertion failed");
`else
`define SAI_ASSERT(label, clk, rstn, ante, cons)
`define SAI_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/sai_pkg.sv */
package sai_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 6;
    // wide enough for any cell index up to 511
    localparam int IDXCMP_W  = 9;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic                       eval;
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } sai_cmd_t;

endpackage

/* rtl/core/sorted_array_insert_remove.sv */
// Channel | Direction | Ports
// --------+-----------+--------------------------------------------------------
// s_      | in        | s_valid s_ready s_mode s_value s_position
// m_      | out       | m_valid m_ready m_status m_read_value m_count m_is_empty m_is_full
//
// Each word passes three steps: accept, parallel compare in all cells, apply shift; no new word until applied.
// The apply step waits while a previous result is still held on the m_ side.
// aresetn (synchronous) empties the array; stored words keep their old bits.
// Read, remove-miss, full insert and mode 3 leave the array unchanged.
module sorted_array_insert_remove
    import sai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic signed [VALUE_W-1:0]   s_value,
    input  logic [POS_W-1:0]            s_position,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic signed [VALUE_W-1:0]   m_read_value,
    output logic [COUNT_W-1:0]          m_count,
    output logic                        m_is_empty,
    output logic                        m_is_full
);

    `include "sorted_array_insert_remove_macros.svh"

    localparam int CNT_W = $clog2(DEPTH+1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } state_t;

    state_t                     state_reg;
    logic [1:0]                 mode_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic [POS_W-1:0]           position_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       m_valid_reg;
    logic [1:0]                 status_reg;
    logic signed [VALUE_W-1:0]  read_value_reg;
    logic [COUNT_W-1:0]         count_out_reg;
    logic                       empty_reg;
    logic                       full_reg;

    sai_cmd_t                   cmd;
    logic signed [VALUE_W-1:0]  cell_val [DEPTH];
    logic [DEPTH-1:0]           cell_le;
    logic [DEPTH-1:0]           cell_eq;
    logic [DEPTH-1:0]           cell_hit;
    logic signed [VALUE_W-1:0]  cell_rd [DEPTH];
    logic signed [VALUE_W-1:0]  rd_or;
    logic                       out_free;
    logic                       apply_go;
    logic                       is_full_now;
    logic                       found;
    logic                       ins_en;
    logic                       rem_en;
    logic [1:0]                 status_next;
    logic [CNT_W+COUNT_W-1:0]   count_ext;

    assign s_ready     = (state_reg == S_IDLE);
    assign out_free    = !m_valid_reg || m_ready;
    assign apply_go    = (state_reg == S_APPLY) && out_free;
    assign is_full_now = (count_reg == CNT_W'(DEPTH));
    assign found       = |cell_eq;
    assign ins_en      = apply_go && (mode_reg == MODE_INSERT) && !is_full_now;
    assign rem_en      = apply_go && (mode_reg == MODE_REMOVE) && found;

    assign cmd.eval     = (state_reg == S_EVAL);
    assign cmd.ins      = ins_en;
    assign cmd.rem      = rem_en;
    assign cmd.value    = value_reg;
    assign cmd.position = position_reg;

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rem_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_INSERT: status_next = is_full_now ? ST_FULL : ST_OK;
            MODE_REMOVE: status_next = found ? ST_OK : ST_NOT_FOUND;
            MODE_READ:   status_next = (|cell_hit) ? ST_OK : ST_RANGE;
            default:     status_next = ST_OK;
        endcase
    end

    // report the low bits of the count
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [VALUE_W-1:0] pv;
            logic                      pl;
            logic signed [VALUE_W-1:0] nv;
            if (g == 0) begin : g_first
                assign pv = '0;
                assign pl = 1'b1;
            end else begin : g_mid
                assign pv = cell_val[g-1];
                assign pl = cell_le[g-1];
            end
            if (g == DEPTH-1) begin : g_last
                assign nv = '0;
            end else begin : g_inner
                assign nv = cell_val[g+1];
            end
            sai_cell #(
                .DEPTH (DEPTH),
                .INDEX (g)
            ) u_cell (
                .aclk     (aclk),
                .cmd      (cmd),
                .count    (count_reg),
                .prev_val (pv),
                .prev_le  (pl),
                .next_val (nv),
                .val      (cell_val[g]),
                .le       (cell_le[g]),
                .eq       (cell_eq[g]),
                .hit      (cell_hit[g]),
                .rd       (cell_rd[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !apply_go) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg     <= s_mode;
                        value_reg    <= s_value;
                        position_reg <= s_position;
                        state_reg    <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (out_free) begin
                        count_reg      <= count_next;
                        m_valid_reg    <= 1'b1;
                        status_reg     <= status_next;
                        read_value_reg <= (mode_reg == MODE_READ) ? rd_or : '0;
                        count_out_reg  <= count_ext[COUNT_W-1:0];
                        empty_reg      <= (count_next == '0);
                        full_reg       <= (count_next == CNT_W'(DEPTH));
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_read_value = read_value_reg;
    assign m_count      = count_out_reg;
    assign m_is_empty   = empty_reg;
    assign m_is_full    = full_reg;

    `SAI_ASSERT(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SAI_ASSERT_NEXT(a_ins_count, aclk, aresetn, ins_en, count_reg == $past(count_reg) + CNT_W'(1))
    `SAI_ASSERT(a_found_nonempty, aclk, aresetn, (state_reg == S_APPLY) && found, count_reg != '0)
    `SAI_ASSERT(a_hit_onehot, aclk, aresetn, state_reg == S_APPLY, $onehot0(cell_hit))

endmodule

/* rtl/core/sai_cell.sv */
module sai_cell
    import sai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  logic                          aclk,
    input  sai_cmd_t                      cmd,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic signed [VALUE_W-1:0]     prev_val,
    input  logic                          prev_le,
    input  logic signed [VALUE_W-1:0]     next_val,
    output logic signed [VALUE_W-1:0]     val,
    output logic                          le,
    output logic                          eq,
    output logic                          hit,
    output logic signed [VALUE_W-1:0]     rd
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic signed [VALUE_W-1:0] e_reg;
    logic                      le_reg;
    logic                      lt_reg;
    logic                      eq_reg;
    logic                      hit_reg;
    logic                      in_use;

    assign in_use = (count > CNT_W'(INDEX));

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            le_reg  <= in_use && (e_reg <= cmd.value);
            lt_reg  <= in_use && (e_reg <  cmd.value);
            eq_reg  <= in_use && (e_reg == cmd.value);
            hit_reg <= in_use && (IDXCMP_W'(cmd.position) == IDXCMP_W'(INDEX));
        end
        if (cmd.ins) begin
            // keep smaller-or-equal words, place the new word at the boundary, shift the rest up
            if (!le_reg) begin
                e_reg <= prev_le ? cmd.value : prev_val;
            end
        end else if (cmd.rem) begin
            // close the gap from the first matching word upward
            if (!lt_reg) begin
                e_reg <= next_val;
            end
        end
    end

    assign val = e_reg;
    assign le  = le_reg;
    assign eq  = eq_reg;
    assign hit = hit_reg;
    assign rd  = hit_reg ? e_reg : '0;

endmodule
